[sv/lease_lock_table_defines.svh]
// Assertion macros for the lease lock table.
// Needs clk and rst_n in the including scope.
`ifndef LEASE_LOCK_TABLE_DEFINES_SVH
`define LEASE_LOCK_TABLE_DEFINES_SVH
// same-cycle implication, quiet during reset
`define LLT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lease_lock_table: same-cycle check failed");
// next-cycle implication, quiet during reset
`define LLT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lease_lock_table: next-cycle check failed");
`endif

[sv/llt_pkg.sv]
// Shared types and constants of the lease lock table.
// No dependencies.
`default_nettype none
package llt_pkg;
  localparam int KEY_W   = 48;
  localparam int AGE_W   = 17;
  localparam logic [AGE_W-1:0] MAX_AGE_RESET = 17'd3600;

  localparam logic [1:0] KIND_LOCK    = 2'd0;
  localparam logic [1:0] KIND_REMOVE  = 2'd1;
  localparam logic [1:0] KIND_CONFIRM = 2'd2;
  localparam logic [1:0] KIND_BAD     = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_REFUSED   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_RETRY     = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_BAD       = 3'd5;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE} llt_state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [15:0]      owner;
    logic [31:0]      sequence_no;
    logic [31:0]      stamp;
    logic [31:0]      ip;
    logic [14:0]      coll;
    logic             confirmed;
  } llt_entry_t;
endpackage
`default_nettype wire

[sv/llt_store.sv]
// Entry store: one write port, one read port with registered data.
// Depends on llt_pkg.
`default_nettype none
module llt_store #(
  parameter int DEPTH = 256
) (
  input  wire                       clk,
  input  wire                       wr_en,
  input  wire [$clog2(DEPTH)-1:0]   wr_addr,
  input  llt_pkg::llt_entry_t       wr_data,
  input  wire [$clog2(DEPTH)-1:0]   rd_addr,
  output llt_pkg::llt_entry_t       rd_data
);
  import llt_pkg::*;

  llt_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

[sv/lease_lock_table.sv]
// Lease lock table: a transaction scans the entry memory linearly, one read a
// cycle, then decides in S_DECIDE and strobes out_valid from a register. A start
// is taken only while idle, so a new start waits until the last one is done.
// Results are strobed for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears valid bits and control and restores the age limit.
`default_nettype none
module lease_lock_table #(
  parameter int LOCK_ENTRIES = 256
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  in_kind,
  input  wire  [47:0] in_lock_key,
  input  wire  [31:0] in_lock_sequence,
  input  wire  [31:0] in_first_ip,
  input  wire  [14:0] in_collection,
  input  wire  [15:0] in_requester_host,
  input  wire  [31:0] in_now_seconds,
  input  wire         in_clock_synced,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic        out_grant,
  output logic        out_stale_dropped,
  output logic        out_entry_removed,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import llt_pkg::*;

  localparam int IW = $clog2(LOCK_ENTRIES);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] CNT_END = CW'(LOCK_ENTRIES);

  // configuration
  logic [AGE_W-1:0] age_r;
  logic             cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {{(32-AGE_W){1'b0}}, age_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_r <= MAX_AGE_RESET;
    end else if (cfg_wr) begin
      age_r <= pwdata[AGE_W-1:0];
    end
  end

  // captured request (payload, no reset)
  logic [1:0]  kind_r;
  logic [47:0] key_r;
  logic [31:0] seq_r, ip_r, now_r;
  logic [14:0] coll_r;
  logic [15:0] host_r;
  logic        sync_r;

  llt_state_t state_r, state_nxt;
  logic       accept;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      key_r  <= in_lock_key;
      seq_r  <= in_lock_sequence;
      ip_r   <= in_first_ip;
      now_r  <= in_now_seconds;
      coll_r <= in_collection;
      host_r <= in_requester_host;
      sync_r <= in_clock_synced;
    end
  end

  // scan pipeline: issue a read at cnt, compare the returning entry in the next cycle
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]   cmp_idx_r;
  logic [LOCK_ENTRIES-1:0] valid_r;
  llt_entry_t      rd_data;
  logic            hit_r, free_r;
  logic [IW-1:0]   hit_idx_r, free_idx_r;
  llt_entry_t      hit_word_r;
  logic            issue;

  // decision outputs
  logic            wr_en, clr_en, set_en;
  logic [IW-1:0]   wr_addr, clr_idx;
  llt_entry_t      wr_data;
  logic [2:0]      res_status;
  logic            res_grant, res_stale, res_removed, res_fire;
  logic [31:0]     diff;
  logic            stale;
  logic [IW-1:0]   free_sel;
  logic            have_free;

  llt_store #(.DEPTH(LOCK_ENTRIES)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (cnt_r[IW-1:0]),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept) state_nxt = S_SCAN;
      S_SCAN:   if (cnt_r == CNT_END) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  assign issue       = (state_r == S_SCAN) && (cnt_r != CNT_END);
  assign cnt_nxt     = (state_r == S_IDLE) ? '0 : (issue ? cnt_r + 1'b1 : cnt_r);
  assign cmp_vld_nxt = issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  // track first key match and lowest free entry while scanning
  always_ff @(posedge clk) begin
    cmp_idx_r <= cnt_r[IW-1:0];
    if (accept) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (cmp_vld_r) begin
      if (valid_r[cmp_idx_r] && rd_data.key == key_r && !hit_r) begin
        hit_r      <= 1'b1;
        hit_idx_r  <= cmp_idx_r;
        hit_word_r <= rd_data;
      end
      if (!valid_r[cmp_idx_r] && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= cmp_idx_r;
      end
    end
  end

  // outputs and decision
  assign diff      = now_r - hit_word_r.stamp;
  assign stale     = hit_r && !diff[31] && (diff > {{(32-AGE_W){1'b0}}, age_r});
  assign free_sel  = (stale && (!free_r || hit_idx_r < free_idx_r)) ? hit_idx_r : free_idx_r;
  assign have_free = free_r || stale;

  always_comb begin
    busy        = (state_r != S_IDLE);
    res_fire    = (state_r == S_DECIDE);
    wr_en       = 1'b0;
    wr_addr     = free_sel;
    wr_data     = hit_word_r;
    clr_en      = 1'b0;
    clr_idx     = hit_idx_r;
    set_en      = 1'b0;
    res_status  = ST_OK;
    res_grant   = 1'b0;
    res_stale   = 1'b0;
    res_removed = 1'b0;
    if (res_fire) begin
      if (kind_r == KIND_BAD) begin
        res_status = ST_BAD;
      end else if (kind_r == KIND_CONFIRM) begin
        if (hit_r) begin
          wr_en             = 1'b1;
          wr_addr           = hit_idx_r;
          wr_data.confirmed = 1'b1;
          res_grant         = 1'b1;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end else if (!sync_r) begin
        res_status = ST_RETRY;
      end else if (kind_r == KIND_REMOVE) begin
        res_grant = 1'b1;
        if (hit_r && hit_word_r.owner == host_r && hit_word_r.sequence_no == seq_r) begin
          clr_en      = 1'b1;
          res_removed = 1'b1;
        end
      end else begin
        // lock request: drop an aged lock, refuse a live one, else take a slot or report full
        clr_en    = stale;
        res_stale = stale;
        if (hit_r && !stale) begin
          res_status = ST_REFUSED;
        end else if (!have_free) begin
          res_status = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          set_en  = 1'b1;
          wr_data = '{key: key_r, owner: host_r, sequence_no: seq_r, stamp: now_r,
                      ip: ip_r, coll: coll_r, confirmed: 1'b0};
          res_grant = 1'b1;
        end
      end
    end
  end

  // valid map: a reused slot is only set, never cleared in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (clr_en && !(set_en && wr_addr == clr_idx)) valid_r[clr_idx] <= 1'b0;
      if (set_en) valid_r[wr_addr] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= res_fire;
    end
    if (res_fire) begin
      out_status        <= res_status;
      out_grant         <= res_grant;
      out_stale_dropped <= res_stale;
      out_entry_removed <= res_removed;
    end
  end

`include "lease_lock_table_defines.svh"
`LLT_ASSERT_IMP(a_out_when_idle, out_valid, !busy)
`LLT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
`LLT_ASSERT_IMP(a_ok_grants, out_valid && out_status == ST_OK, out_grant)
`LLT_ASSERT_IMP(a_flags_excl, out_valid && out_stale_dropped, !out_entry_removed)

endmodule
`default_nettype wire
